FILE: hw/rtl/ccc_pkg.sv
// Package for the transport stream continuity counter checker.
// Holds table sizing, header constants and the entry and write request types.
// No dependencies.
package ccc_pkg;

    localparam int NUM_IDS = 8192;
    localparam int IDX_W   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int PID_W   = 13;
    localparam int CNT_W   = 4;
    localparam int HDR_W   = 32;

    localparam logic [7:0]       SYNC_BYTE = 8'h47;
    localparam logic [PID_W-1:0] NULL_ID   = 13'h1FFF;

    typedef struct packed {
        logic             seen;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } wr_t;

    function automatic logic [PID_W-1:0] hdr_pid(input logic [HDR_W-1:0] hdr);
        return hdr[20:8];
    endfunction

    function automatic logic [IDX_W-1:0] hdr_idx(input logic [HDR_W-1:0] hdr);
        logic [PID_W-1:0] pid;
        pid = hdr[20:8];
        return pid[IDX_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/ccc_table.sv
// Per-identifier counter table: one synchronous memory of seen bit and counter.
// Runs a clearing pass after reset and forwards the last write to a late read.
// Depends on ccc_pkg.
module ccc_table
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [ccc_pkg::IDX_W-1:0] rd_idx,
    output ccc_pkg::entry_t          rd_data,
    input  ccc_pkg::wr_t             wr,
    output logic                     clearing
);

    ccc_pkg::entry_t             mem [ccc_pkg::NUM_IDS];
    ccc_pkg::entry_t             rdata_reg;
    logic [ccc_pkg::IDX_W-1:0]   rd_idx_reg;

    logic                        clr_busy_reg;
    logic [ccc_pkg::IDX_W-1:0]   clr_idx_reg;

    logic                        lw_valid_reg;
    logic [ccc_pkg::IDX_W-1:0]   lw_idx_reg;
    ccc_pkg::entry_t             lw_data_reg;

    ccc_pkg::wr_t                wq;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            wq.en   = 1'b1;
            wq.idx  = clr_idx_reg;
            wq.data = '0;
        end
        else
        begin
            wq = wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wq.en)
        begin
            mem[wq.idx] <= wq.data;
        end
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_idx];
            rd_idx_reg <= rd_idx;
        end
        if (wr.en && !clr_busy_reg)
        begin
            lw_idx_reg  <= wr.idx;
            lw_data_reg <= wr.data;
        end
    end

    // Walk every entry once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_idx_reg == ccc_pkg::IDX_W'(ccc_pkg::NUM_IDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            else if (wr.en)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    // Forward a write that landed on the same edge as the read
    assign rd_data  = (lw_valid_reg && (lw_idx_reg == rd_idx_reg)) ? lw_data_reg : rdata_reg;
    assign clearing = clr_busy_reg;

endmodule

FILE: hw/rtl/ccc_check.sv
// Check stage and output register: compares the received counter with the
// table entry, issues the table update and holds the result for the consumer.
// Depends on ccc_pkg.
module ccc_check
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ccc_pkg::HDR_W-1:0]  header_word,
    input  logic                       clearing,
    output logic                       rd_en,
    output logic [ccc_pkg::IDX_W-1:0]  rd_idx,
    input  ccc_pkg::entry_t            rd_data,
    output ccc_pkg::wr_t               wr,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       keep,
    output logic                       sync_error,
    output logic                       cc_error,
    output logic [ccc_pkg::PID_W-1:0]  packet_id,
    output logic [ccc_pkg::CNT_W-1:0]  expected_count,
    output logic [ccc_pkg::CNT_W-1:0]  received_count
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [ccc_pkg::HDR_W-1:0]  s1_hdr_reg;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       keep_reg;
    logic                       sync_error_reg;
    logic                       cc_error_reg;
    logic [ccc_pkg::PID_W-1:0]  packet_id_reg;
    logic [ccc_pkg::CNT_W-1:0]  expected_count_reg;
    logic [ccc_pkg::CNT_W-1:0]  received_count_reg;

    logic                       s1_go;
    logic                       in_fire;
    logic [ccc_pkg::PID_W-1:0]  pid;
    logic [ccc_pkg::CNT_W-1:0]  rx;
    logic                       is_null;
    logic                       tracked;
    logic [ccc_pkg::CNT_W-1:0]  expect_cnt;
    logic                       cc_err;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing && (!s1_valid_reg || s1_go);
    assign in_fire  = in_valid && in_ready;
    assign rd_en    = in_fire;
    assign rd_idx   = ccc_pkg::hdr_idx(header_word);

    always_comb
    begin
        pid     = ccc_pkg::hdr_pid(s1_hdr_reg);
        rx      = s1_hdr_reg[ccc_pkg::CNT_W-1:0];
        is_null = (pid == ccc_pkg::NULL_ID);
        tracked = !is_null &&
                  ({1'b0, pid} < (ccc_pkg::PID_W + 1)'(ccc_pkg::NUM_IDS));
        if (tracked && rd_data.seen)
        begin
            expect_cnt = rd_data.count + 1'b1;
            cc_err     = (expect_cnt != rx);
        end
        else
        begin
            expect_cnt = '0;
            cc_err     = 1'b0;
        end
        wr.en         = s1_go && tracked;
        wr.idx        = pid[ccc_pkg::IDX_W-1:0];
        wr.data.seen  = 1'b1;
        wr.data.count = rx;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_hdr_reg <= header_word;
        end
        if (s1_go)
        begin
            keep_reg           <= !is_null;
            sync_error_reg     <= (s1_hdr_reg[31:24] != ccc_pkg::SYNC_BYTE);
            cc_error_reg       <= cc_err;
            packet_id_reg      <= pid;
            expected_count_reg <= expect_cnt;
            received_count_reg <= rx;
        end
    end

    assign out_valid      = out_valid_reg;
    assign keep           = keep_reg;
    assign sync_error     = sync_error_reg;
    assign cc_error       = cc_error_reg;
    assign packet_id      = packet_id_reg;
    assign expected_count = expected_count_reg;
    assign received_count = received_count_reg;

endmodule

FILE: hw/rtl/ts_continuity_counter_check_top.sv
// Top level of the transport stream continuity counter checker.
// Instantiates the counter table and the check stage. Depends on ccc_pkg,
// ccc_table and ccc_check.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   header_word[31:0]
//   output    out_valid / out_ready keep, sync_error, cc_error, packet_id,
//                                   expected_count, received_count
//
// One request per cycle unless the output stalls or the table is clearing.
// A result is registered in the check stage and then in the output register.
// The registered table read forwards a same-identifier update from the
// previous request from the last-write register. After reset a clearing pass
// walks all NUM_IDS (8192) entries with in_ready low throughout.
// A stalled output holds the check stage; in_ready also drops when both are full.
module ts_continuity_counter_check_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ccc_pkg::HDR_W-1:0]  header_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       keep,
    output logic                       sync_error,
    output logic                       cc_error,
    output logic [ccc_pkg::PID_W-1:0]  packet_id,
    output logic [ccc_pkg::CNT_W-1:0]  expected_count,
    output logic [ccc_pkg::CNT_W-1:0]  received_count
);

    logic                       rd_en;
    logic [ccc_pkg::IDX_W-1:0]  rd_idx;
    ccc_pkg::entry_t            rd_data;
    ccc_pkg::wr_t               wr;
    logic                       clearing;

    ccc_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_data  (rd_data),
        .wr       (wr),
        .clearing (clearing)
    );

    ccc_check u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .header_word    (header_word),
        .clearing       (clearing),
        .rd_en          (rd_en),
        .rd_idx         (rd_idx),
        .rd_data        (rd_data),
        .wr             (wr),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keep           (keep),
        .sync_error     (sync_error),
        .cc_error       (cc_error),
        .packet_id      (packet_id),
        .expected_count (expected_count),
        .received_count (received_count)
    );

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !wr.en && !in_ready)
        else $error("table update or request taken during clearing pass");

    a_null_untracked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !keep |-> !cc_error && (expected_count == '0))
        else $error("null packet reported a counter check");

    a_cc_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cc_error |-> (expected_count != received_count))
        else $error("counter error raised on matching counters");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packet_id) &&
                                    $stable(received_count))
        else $error("stalled result changed before it was taken");

endmodule
